// File: rtl/srrw_pkg.sv
// Package: shared constants, result codes and the command type of the receive window.
package srrw_pkg;

  localparam int WINDOW = 8;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [12:0] MAX_PAYLOAD = 13'(8000 - 13);

  localparam logic [1:0] PKT_DATA = 2'd0;
  localparam logic [1:0] PKT_FIN  = 2'd1;

  localparam logic [1:0] OUT_DELIVER = 2'd0;
  localparam logic [1:0] OUT_ACK     = 2'd1;
  localparam logic [1:0] OUT_FIN     = 2'd2;

  typedef struct packed {
    logic        fin;
    logic [31:0] seq;
    logic [12:0] len;
    logic [15:0] tag;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_DRAIN
  } back_state_e;

endpackage

// File: rtl/selective_repeat_receive_window_unit.sv
// Top level: selective-repeat receive window with decoupled front end and window engine.
//
// Usage:
//   A packet header (kind, sequence number, length, buffer tag) is taken at a clock edge
//   with start_i high and busy_o low. busy_o is high only while the two-entry command
//   queue is full.
//   Results leave on out_*_o, each valid for one cycle while out_valid_o is high;
//   last_result_o marks the final result of a header. The receiver cannot stall, so
//   results are never held.
//   Flow: a data header passes the command queue to the window engine, which stores it if
//   it falls in the window and its slot is free, then gives one delivery per in-order
//   filled slot and then the ack, each result registered. A data header thus gives D
//   deliveries (at most 8) and one ack; a fin header gives one fin result. Dropped kinds
//   and all headers after a fin take no engine time and give no result. While the engine
//   drains its slots it takes no new header; waiting headers stay queued until it is done.
//   Reset: asynchronous, active low; empties the queue and the window, next expected
//   sequence number returns to zero and the block reopens. No clearing pass is needed.
module selective_repeat_receive_window_unit
  import srrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  pkt_kind_i,
  input  logic [31:0] seq_num_i,
  input  logic [12:0] payload_len_i,
  input  logic [15:0] payload_tag_i,
  output logic        out_valid_o,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_seq_o,
  output logic [12:0] out_len_o,
  output logic [15:0] out_tag_o,
  output logic        last_result_o
);

  logic q_full, q_empty, push, pop;
  cmd_t front_cmd, back_cmd;

  srrw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .pkt_kind_i    (pkt_kind_i),
    .seq_num_i     (seq_num_i),
    .payload_len_i (payload_len_i),
    .payload_tag_i (payload_tag_i),
    .q_full_i      (q_full),
    .busy_o        (busy_o),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  srrw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (back_cmd)
  );

  srrw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .cmd_i         (back_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_kind_o    (out_kind_o),
    .out_seq_o     (out_seq_o),
    .out_len_o     (out_len_o),
    .out_tag_o     (out_tag_o),
    .last_result_o (last_result_o)
  );

endmodule

// File: rtl/srrw_front.sv
// Front end: accepts packet headers, drops unknown kinds and post-fin traffic, clamps length.
module srrw_front
  import srrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  pkt_kind_i,
  input  logic [31:0] seq_num_i,
  input  logic [12:0] payload_len_i,
  input  logic [15:0] payload_tag_i,
  input  logic        q_full_i,
  output logic        busy_o,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic closed_q, closed_d;
  logic accept;
  logic is_data, is_fin;

  assign busy_o  = q_full_i;
  assign accept  = start_i & ~q_full_i;
  assign is_data = (pkt_kind_i == PKT_DATA);
  assign is_fin  = (pkt_kind_i == PKT_FIN);
  assign push_o  = accept & ~closed_q & (is_data | is_fin);

  always_comb begin
    cmd_o.fin = is_fin;
    cmd_o.seq = seq_num_i;
    cmd_o.len = (payload_len_i > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_len_i;
    cmd_o.tag = payload_tag_i;
  end

  assign closed_d = closed_q | (push_o & is_fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
    end else begin
      closed_q <= closed_d;
    end
  end

endmodule

// File: rtl/srrw_queue.sv
// Short command queue between the front end and the window engine.
module srrw_queue
  import srrw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output cmd_t  cmd_o
);

  cmd_t                mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/srrw_back.sv
// Window engine: slot store, in-order drain and cumulative ack / fin reply generation.
module srrw_back
  import srrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_seq_o,
  output logic [12:0] out_len_o,
  output logic [15:0] out_tag_o,
  output logic        last_result_o
);

  back_state_e state_q, state_d;

  logic              slot_valid_q [WINDOW];
  logic [12:0]       slot_len_q   [WINDOW];
  logic [15:0]       slot_tag_q   [WINDOW];
  logic [31:0]       next_q;
  logic [SLOT_W-1:0] head_q, head_nxt;

  logic [31:0]       seq_off;
  logic              in_win;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_idx;
  logic              head_valid;

  logic store_en, deliver_en, ack_en, fin_en;

  logic        out_valid_q, last_q;
  logic [1:0]  out_kind_q;
  logic [31:0] out_seq_q;
  logic [12:0] out_len_q;
  logic [15:0] out_tag_q;

  assign seq_off  = cmd_i.seq - next_q;
  assign in_win   = (seq_off < 32'(WINDOW));
  assign slot_sum = {1'b0, head_q} + {1'b0, seq_off[SLOT_W-1:0]};
  assign slot_idx = (slot_sum >= (SLOT_W + 1)'(WINDOW))
                    ? SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW))
                    : slot_sum[SLOT_W-1:0];
  assign head_nxt = (head_q == SLOT_W'(WINDOW - 1)) ? '0 : head_q + 1'b1;
  assign head_valid = slot_valid_q[head_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i && !cmd_i.fin) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!head_valid) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    store_en   = 1'b0;
    fin_en     = 1'b0;
    deliver_en = 1'b0;
    ack_en     = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        pop_o    = ~q_empty_i;
        fin_en   = ~q_empty_i & cmd_i.fin;
        store_en = ~q_empty_i & ~cmd_i.fin & in_win & ~slot_valid_q[slot_idx];
      end
      B_DRAIN: begin
        deliver_en = head_valid;
        ack_en     = ~head_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      next_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= deliver_en | ack_en | fin_en;
      if (store_en) begin
        slot_valid_q[slot_idx] <= 1'b1;
      end
      if (deliver_en) begin
        slot_valid_q[head_q] <= 1'b0;
        next_q               <= next_q + 32'd1;
        head_q               <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      slot_len_q[slot_idx] <= cmd_i.len;
      slot_tag_q[slot_idx] <= cmd_i.tag;
    end
    if (deliver_en) begin
      out_kind_q <= OUT_DELIVER;
      out_seq_q  <= next_q;
      out_len_q  <= slot_len_q[head_q];
      out_tag_q  <= slot_tag_q[head_q];
      last_q     <= 1'b0;
    end else if (ack_en) begin
      out_kind_q <= OUT_ACK;
      out_seq_q  <= next_q - 32'd1;
      out_len_q  <= '0;
      out_tag_q  <= '0;
      last_q     <= 1'b1;
    end else if (fin_en) begin
      out_kind_q <= OUT_FIN;
      out_seq_q  <= '0;
      out_len_q  <= '0;
      out_tag_q  <= '0;
      last_q     <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_seq_o     = out_seq_q;
  assign out_len_o     = out_len_q;
  assign out_tag_o     = out_tag_q;
  assign last_result_o = last_q;

  a_idle_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_IDLE |-> !slot_valid_q[head_q])
    else $error("head slot still filled while idle");

  a_deliver_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == OUT_DELIVER |=> out_valid_q)
    else $error("delivery not followed by another result");

  a_deliver_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == OUT_DELIVER ##1
    out_valid_q && out_kind_q == OUT_DELIVER |-> out_seq_q == $past(out_seq_q) + 32'd1)
    else $error("consecutive deliveries not in sequence");

  a_ack_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == OUT_ACK && $past(out_valid_q)
    && $past(out_kind_q) == OUT_DELIVER |-> out_seq_q == $past(out_seq_q))
    else $error("ack does not match last delivered sequence number");

endmodule
